// ===== src/oal_pkg.sv =====
// shared constants, types and the candidate merge function of the ordered array list
package oal_pkg;

  // list size and derived widths
  localparam int CAPACITY   = 128;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int OP_W       = 3;
  localparam int POS_W      = 8;
  localparam int VAL_W      = 8;
  localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // reduction grouping: cells per group (power of two), groups and padded group count
  localparam int GROUP_SIZE = 16;
  localparam int NGROUP     = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int NGROUP_P2  = 2 ** $clog2(NGROUP);
  localparam int NCELL_PAD  = NGROUP * GROUP_SIZE;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT_AT    = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE_AT    = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE_VALUE = 3'd2;
  localparam logic [OP_W-1:0] OP_READ_AT      = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND_VALUE   = 3'd4;
  localparam logic [OP_W-1:0] OP_GET_MAX      = 3'd5;

  // what every cell does with its entry in a cycle
  typedef enum logic [1:0] {
    SH_HOLD,
    SH_INSERT,
    SH_DELETE
  } shift_mode_t;

  // compare controls broadcast to the cells
  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] key;
    logic [IDX_W-1:0]        tgt;
    logic [CNT_W-1:0]        cnt;
  } scan_t;

  // shift controls broadcast to the cells
  typedef struct packed {
    shift_mode_t             mode;
    logic [IDX_W-1:0]        tgt;
    logic signed [VAL_W-1:0] val;
  } shift_t;

  // one cell's bid in the reduction
  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        idx;
  } cand_t;

  // merge two bids, lo from lower positions; lower position wins ties
  function automatic cand_t combine(cand_t lo, cand_t hi, logic use_max);
    cand_t res;
    if (!lo.valid) begin
      res = hi;
    end else if (!hi.valid) begin
      res = lo;
    end else if (use_max && ($signed(hi.value) > $signed(lo.value))) begin
      res = hi;
    end else begin
      res = lo;
    end
    return res;
  endfunction

endpackage

// ===== src/oal_cell.sv =====
// one list cell: holds an entry, bids in the reduction, shifts with its neighbors
module oal_cell (
  input  logic                                 clk,
  input  logic [oal_pkg::IDX_W-1:0]            idx_i,
  input  oal_pkg::scan_t                       scan_i,
  input  oal_pkg::shift_t                      shift_i,
  input  logic signed [oal_pkg::VAL_W-1:0]     left_i,
  input  logic signed [oal_pkg::VAL_W-1:0]     right_i,
  output logic signed [oal_pkg::VAL_W-1:0]     data_o,
  output oal_pkg::cand_t                       cand_o
);

  logic signed [oal_pkg::VAL_W-1:0] entry_r;
  logic signed [oal_pkg::VAL_W-1:0] entry_nxt;
  logic                             in_list;
  logic                             hit;

  assign data_o  = entry_r;
  assign in_list = oal_pkg::CNT_W'(idx_i) < scan_i.cnt;

  // match condition for the requested operation
  always_comb begin
    case (scan_i.op)
      oal_pkg::OP_READ_AT,
      oal_pkg::OP_DELETE_AT:    hit = (idx_i == scan_i.tgt);
      oal_pkg::OP_DELETE_VALUE,
      oal_pkg::OP_FIND_VALUE:   hit = (entry_r == scan_i.key);
      oal_pkg::OP_GET_MAX:      hit = 1'b1;
      default:                  hit = 1'b0;
    endcase
  end

  always_comb begin
    cand_o.valid = in_list & hit;
    cand_o.value = entry_r;
    cand_o.idx   = idx_i;
  end

  // shift up on insert, down on delete
  always_comb begin
    entry_nxt = entry_r;
    case (shift_i.mode)
      oal_pkg::SH_INSERT: begin
        if (idx_i > shift_i.tgt) begin
          entry_nxt = left_i;
        end else if (idx_i == shift_i.tgt) begin
          entry_nxt = shift_i.val;
        end
      end
      oal_pkg::SH_DELETE: begin
        if (idx_i >= shift_i.tgt) begin
          entry_nxt = right_i;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== src/oal_group.sv =====
// reduction tree over one group of cell bids
module oal_group (
  input  oal_pkg::cand_t cand_i [oal_pkg::GROUP_SIZE],
  input  logic           use_max_i,
  output oal_pkg::cand_t cand_o
);

  oal_pkg::cand_t node [1:2*oal_pkg::GROUP_SIZE-1];

  // heap-ordered tree, lower positions on the left
  always_comb begin
    for (int j = 0; j < oal_pkg::GROUP_SIZE; j++) begin
      node[oal_pkg::GROUP_SIZE + j] = cand_i[j];
    end
    for (int k = oal_pkg::GROUP_SIZE - 1; k >= 1; k--) begin
      node[k] = oal_pkg::combine(node[2*k], node[2*k+1], use_max_i);
    end
    cand_o = node[1];
  end

endmodule

// ===== src/ordered_array_list_core.sv =====
// top level of the ordered array list: cell row, two-level reduction, control and result register
//
//   channel | direction | ports                                         | transfer when
//   --------+-----------+-----------------------------------------------+-------------------------
//   in      | into      | in_operation, in_position, in_value_in        | in_valid & in_ready
//   out     | out of    | out_ok, out_value_out, out_position_out,      | out_valid & out_ready
//           |           | out_list_count, out_is_empty                  |
//
// for each request, group bids are reduced and registered at the input transfer; in the
// done state the group results are merged, the cells shift and the result register loads.
// the cross-cell reduction is split into two levels (groups of 16, then the group tree).
// a new request is taken while a finished result still waits in the output register.
// the commit cycle stalls while the output register is full and not being taken.
// reset clears the length and the output valid; entry contents are not cleared.
module ordered_array_list_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [oal_pkg::OP_W-1:0]            in_operation,
  input  logic [oal_pkg::POS_W-1:0]           in_position,
  input  logic signed [oal_pkg::VAL_W-1:0]    in_value_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_ok,
  output logic signed [oal_pkg::VAL_W-1:0]    out_value_out,
  output logic [oal_pkg::POS_W-1:0]           out_position_out,
  output logic [oal_pkg::POS_W-1:0]           out_list_count,
  output logic                                out_is_empty
);

  typedef enum logic {
    ST_IDLE,
    ST_DONE
  } state_t;

  state_t                                state_r;
  logic [oal_pkg::OP_W-1:0]              op_r;
  logic [oal_pkg::POS_W-1:0]             pos_r;
  logic signed [oal_pkg::VAL_W-1:0]      val_r;
  logic [oal_pkg::CNT_W-1:0]             cnt_r;
  logic [oal_pkg::CNT_W-1:0]             cnt_nxt;
  oal_pkg::cand_t                        grp_r [oal_pkg::NGROUP];

  logic                                  out_valid_r;
  logic                                  ok_r;
  logic signed [oal_pkg::VAL_W-1:0]      vout_r;
  logic [oal_pkg::POS_W-1:0]             pout_r;
  logic                                  ok_nxt;
  logic signed [oal_pkg::VAL_W-1:0]      vout_nxt;
  logic [oal_pkg::POS_W-1:0]             pout_nxt;

  logic                                  in_xfer;
  logic                                  commit;
  oal_pkg::scan_t                        scan;
  oal_pkg::shift_t                       shift;
  logic                                  scan_use_max;
  logic                                  fin_use_max;

  logic signed [oal_pkg::VAL_W-1:0]      cell_data [oal_pkg::CAPACITY];
  oal_pkg::cand_t                        cell_cand [oal_pkg::NCELL_PAD];
  oal_pkg::cand_t                        grp_cand  [oal_pkg::NGROUP];
  oal_pkg::cand_t                        fin_node  [1:2*oal_pkg::NGROUP_P2-1];
  oal_pkg::cand_t                        fin;

  logic [oal_pkg::CMP_W-1:0]             pos_w;
  logic [oal_pkg::CMP_W-1:0]             cnt_w;
  logic [oal_pkg::CMP_W-1:0]             fin_pos_w;
  logic [oal_pkg::IDX_W-1:0]             pos_idx;
  logic                                  pos_in_list;
  logic                                  ins_ok;

  // handshakes
  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid & in_ready;
  assign commit    = (state_r == ST_DONE) & (~out_valid_r | out_ready);
  assign out_valid = out_valid_r;

  // compare controls come from the input ports and the length register in the transfer cycle
  always_comb begin
    scan.op      = in_operation;
    scan.key     = in_value_in;
    scan.tgt     = oal_pkg::IDX_W'(oal_pkg::CMP_W'(in_position) - oal_pkg::CMP_W'(1));
    scan.cnt     = cnt_r;
    scan_use_max = (in_operation == oal_pkg::OP_GET_MAX);
    fin_use_max  = (op_r == oal_pkg::OP_GET_MAX);
  end

  // cell row
  for (genvar i = 0; i < oal_pkg::CAPACITY; i++) begin : g_cell
    logic signed [oal_pkg::VAL_W-1:0] left;
    logic signed [oal_pkg::VAL_W-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == oal_pkg::CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    oal_cell u_cell (
      .clk     (clk),
      .idx_i   (oal_pkg::IDX_W'(i)),
      .scan_i  (scan),
      .shift_i (shift),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .cand_o  (cell_cand[i])
    );
  end

  // padding bids past the last cell
  for (genvar i = oal_pkg::CAPACITY; i < oal_pkg::NCELL_PAD; i++) begin : g_pad
    assign cell_cand[i] = '0;
  end

  // first reduction level, one tree per group
  for (genvar g = 0; g < oal_pkg::NGROUP; g++) begin : g_grp
    oal_pkg::cand_t gin [oal_pkg::GROUP_SIZE];
    for (genvar j = 0; j < oal_pkg::GROUP_SIZE; j++) begin : g_in
      assign gin[j] = cell_cand[g*oal_pkg::GROUP_SIZE + j];
    end
    oal_group u_group (
      .cand_i    (gin),
      .use_max_i (scan_use_max),
      .cand_o    (grp_cand[g])
    );
  end

  // second reduction level over registered group results
  always_comb begin
    for (int g = 0; g < oal_pkg::NGROUP_P2; g++) begin
      if (g < oal_pkg::NGROUP) begin
        fin_node[oal_pkg::NGROUP_P2 + g] = grp_r[g];
      end else begin
        fin_node[oal_pkg::NGROUP_P2 + g] = '0;
      end
    end
    for (int k = oal_pkg::NGROUP_P2 - 1; k >= 1; k--) begin
      fin_node[k] = oal_pkg::combine(fin_node[2*k], fin_node[2*k+1], fin_use_max);
    end
    fin = fin_node[1];
  end

  // range checks on the registered request
  always_comb begin
    pos_w       = oal_pkg::CMP_W'(pos_r);
    cnt_w       = oal_pkg::CMP_W'(cnt_r);
    fin_pos_w   = oal_pkg::CMP_W'(fin.idx) + oal_pkg::CMP_W'(1);
    pos_idx     = oal_pkg::IDX_W'(pos_w - oal_pkg::CMP_W'(1));
    pos_in_list = (pos_r != '0) && (pos_w <= cnt_w);
    ins_ok      = (pos_r != '0) && (pos_w <= cnt_w + oal_pkg::CMP_W'(1))
                  && (cnt_w < oal_pkg::CMP_W'(oal_pkg::CAPACITY));
  end

  // result and list update for the registered request
  always_comb begin
    ok_nxt     = 1'b0;
    vout_nxt   = '0;
    pout_nxt   = '0;
    cnt_nxt    = cnt_r;
    shift.mode = oal_pkg::SH_HOLD;
    shift.tgt  = pos_idx;
    shift.val  = val_r;
    case (op_r)
      oal_pkg::OP_INSERT_AT: begin
        if (ins_ok) begin
          ok_nxt     = 1'b1;
          cnt_nxt    = cnt_r + oal_pkg::CNT_W'(1);
          shift.mode = oal_pkg::SH_INSERT;
        end
      end
      oal_pkg::OP_DELETE_AT: begin
        if (pos_in_list) begin
          ok_nxt     = 1'b1;
          vout_nxt   = fin.value;
          pout_nxt   = pos_r;
          cnt_nxt    = cnt_r - oal_pkg::CNT_W'(1);
          shift.mode = oal_pkg::SH_DELETE;
        end
      end
      oal_pkg::OP_DELETE_VALUE: begin
        if (fin.valid) begin
          ok_nxt     = 1'b1;
          vout_nxt   = fin.value;
          pout_nxt   = fin_pos_w[oal_pkg::POS_W-1:0];
          cnt_nxt    = cnt_r - oal_pkg::CNT_W'(1);
          shift.mode = oal_pkg::SH_DELETE;
          shift.tgt  = fin.idx;
        end
      end
      oal_pkg::OP_READ_AT: begin
        if (pos_in_list) begin
          ok_nxt   = 1'b1;
          vout_nxt = fin.value;
          pout_nxt = pos_r;
        end
      end
      oal_pkg::OP_FIND_VALUE: begin
        if (fin.valid) begin
          ok_nxt   = 1'b1;
          pout_nxt = fin_pos_w[oal_pkg::POS_W-1:0];
        end
      end
      oal_pkg::OP_GET_MAX: begin
        if (fin.valid) begin
          ok_nxt   = 1'b1;
          vout_nxt = fin.value;
          pout_nxt = fin_pos_w[oal_pkg::POS_W-1:0];
        end
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
    if (!commit) begin
      shift.mode = oal_pkg::SH_HOLD;
    end
  end

  // control state, request registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
          end
          if (in_xfer) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (commit) begin
            state_r     <= ST_IDLE;
            cnt_r       <= cnt_nxt;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
    if (in_xfer) begin
      op_r  <= in_operation;
      pos_r <= in_position;
      val_r <= in_value_in;
      grp_r <= grp_cand;
    end
    if (commit) begin
      ok_r   <= ok_nxt;
      vout_r <= vout_nxt;
      pout_r <= pout_nxt;
    end
  end

  // result ports
  assign out_ok           = ok_r;
  assign out_value_out    = vout_r;
  assign out_position_out = pout_r;
  assign out_list_count   = oal_pkg::POS_W'(cnt_r);
  assign out_is_empty     = (cnt_r == '0);

endmodule

// ===== dv/ordered_array_list_checker.sv =====
// list model and result comparison for the ordered array list, watching both channels
`timescale 1ns / 100ps

module ordered_array_list_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [oal_pkg::OP_W-1:0]         in_operation,
  input  logic [oal_pkg::POS_W-1:0]        in_position,
  input  logic signed [oal_pkg::VAL_W-1:0] in_value_in,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic                             out_ok,
  input  logic signed [oal_pkg::VAL_W-1:0] out_value_out,
  input  logic [oal_pkg::POS_W-1:0]        out_position_out,
  input  logic [oal_pkg::POS_W-1:0]        out_list_count,
  input  logic                             out_is_empty,
  output int                               mismatches,
  output int                               replies_due,
  output int                               list_len
);

  // one reply as the block reports it
  typedef struct packed {
    logic                             ok;
    logic signed [oal_pkg::VAL_W-1:0] value;
    logic [oal_pkg::POS_W-1:0]        pos;
    logic [oal_pkg::POS_W-1:0]        len;
    logic                             empty;
  } list_reply_t;

  // shadow copy of the list
  logic signed [oal_pkg::VAL_W-1:0] shadow_mem [oal_pkg::CAPACITY];
  int                               shadow_len = 0;
  int                               fault_count = 0;
  list_reply_t                      reply_fifo [$];

  // first 1-based position holding v, 0 if none
  function automatic int first_hit(logic signed [oal_pkg::VAL_W-1:0] v);
    for (int k = 0; k < shadow_len; k++) begin
      if (shadow_mem[k] == v) return k + 1;
    end
    return 0;
  endfunction

  // take out the entry at 1-based position p, closing the hole
  function automatic logic signed [oal_pkg::VAL_W-1:0] take_entry(int p);
    logic signed [oal_pkg::VAL_W-1:0] gone;
    gone = shadow_mem[p-1];
    for (int k = p; k < shadow_len; k++) shadow_mem[k-1] = shadow_mem[k];
    shadow_len--;
    return gone;
  endfunction

  // apply one request to the shadow list and form its reply
  function automatic list_reply_t run_list_request(logic [oal_pkg::OP_W-1:0] op,
                                                   logic [oal_pkg::POS_W-1:0] pos_in,
                                                   logic signed [oal_pkg::VAL_W-1:0] val);
    list_reply_t                      r;
    int                               p;
    int                               hit;
    logic signed [oal_pkg::VAL_W-1:0] best;
    r = '0;
    p = int'(pos_in);
    case (op)
      oal_pkg::OP_INSERT_AT: begin
        if (p >= 1 && p <= shadow_len + 1 && shadow_len < oal_pkg::CAPACITY) begin
          for (int k = shadow_len; k >= p; k--) shadow_mem[k] = shadow_mem[k-1];
          shadow_mem[p-1] = val;
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      oal_pkg::OP_DELETE_AT: begin
        if (p >= 1 && p <= shadow_len) begin
          r.value = take_entry(p);
          r.pos   = oal_pkg::POS_W'(p);
          r.ok    = 1'b1;
        end
      end
      oal_pkg::OP_DELETE_VALUE: begin
        hit = first_hit(val);
        if (hit != 0) begin
          r.value = take_entry(hit);
          r.pos   = oal_pkg::POS_W'(hit);
          r.ok    = 1'b1;
        end
      end
      oal_pkg::OP_READ_AT: begin
        if (p >= 1 && p <= shadow_len) begin
          r.value = shadow_mem[p-1];
          r.pos   = oal_pkg::POS_W'(p);
          r.ok    = 1'b1;
        end
      end
      oal_pkg::OP_FIND_VALUE: begin
        hit = first_hit(val);
        if (hit != 0) begin
          r.pos = oal_pkg::POS_W'(hit);
          r.ok  = 1'b1;
        end
      end
      oal_pkg::OP_GET_MAX: begin
        if (shadow_len > 0) begin
          // strict compare keeps the first position of a repeated maximum
          best  = shadow_mem[0];
          r.pos = oal_pkg::POS_W'(1);
          for (int k = 1; k < shadow_len; k++) begin
            if (shadow_mem[k] > best) begin
              best  = shadow_mem[k];
              r.pos = oal_pkg::POS_W'(k + 1);
            end
          end
          r.value = best;
          r.ok    = 1'b1;
        end
      end
      default: ;
    endcase
    r.len   = oal_pkg::POS_W'(shadow_len);
    r.empty = (shadow_len == 0);
    return r;
  endfunction

  // compare result transfers, then model request transfers
  always @(posedge clk) begin
    list_reply_t got;
    list_reply_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.ok    = out_ok;
        got.value = out_value_out;
        got.pos   = out_position_out;
        got.len   = out_list_count;
        got.empty = out_is_empty;
        if (reply_fifo.size() == 0) begin
          $error("result transfer with no request outstanding");
          fault_count++;
        end else begin
          want = reply_fifo.pop_front();
          if (got.ok !== want.ok) begin
            $error("out_ok: expected %0d, got %0d", want.ok, got.ok);
            fault_count++;
          end
          if (got.value !== want.value) begin
            $error("out_value_out: expected %0d, got %0d",
                   $signed(want.value), $signed(got.value));
            fault_count++;
          end
          if (got.pos !== want.pos) begin
            $error("out_position_out: expected %0d, got %0d", want.pos, got.pos);
            fault_count++;
          end
          if (got.len !== want.len) begin
            $error("out_list_count: expected %0d, got %0d", want.len, got.len);
            fault_count++;
          end
          if (got.empty !== want.empty) begin
            $error("out_is_empty: expected %0d, got %0d", want.empty, got.empty);
            fault_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        reply_fifo.push_back(run_list_request(in_operation, in_position, in_value_in));
      end
    end
    mismatches  <= fault_count;
    replies_due <= reply_fifo.size();
    list_len    <= shadow_len;
  end

endmodule

// ===== dv/testbench.sv =====
// stimulus, reset, clock and verdict for the ordered array list core
`timescale 1ns / 100ps

module testbench;

  // codes the block does not define
  localparam logic [oal_pkg::OP_W-1:0] OP_UNUSED_A = 3'd6;
  localparam logic [oal_pkg::OP_W-1:0] OP_UNUSED_B = 3'd7;
  localparam int RANDOM_ITEMS = 950;

  typedef enum int {PH_FILL, PH_MIX, PH_DRAIN} phase_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [oal_pkg::OP_W-1:0]         in_operation = '0;
  logic [oal_pkg::POS_W-1:0]        in_position = '0;
  logic signed [oal_pkg::VAL_W-1:0] in_value_in = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             out_ok;
  logic signed [oal_pkg::VAL_W-1:0] out_value_out;
  logic [oal_pkg::POS_W-1:0]        out_position_out;
  logic [oal_pkg::POS_W-1:0]        out_list_count;
  logic                             out_is_empty;

  int mismatches;
  int replies_due;
  int list_len;
  bit calm = 1'b0;

  ordered_array_list_core DUT (.*);

  ordered_array_list_checker u_checker (.*);

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_cycles();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [oal_pkg::VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return oal_pkg::VAL_W'(-128);
      1:       return oal_pkg::VAL_W'(127);
      2, 3, 4: return oal_pkg::VAL_W'(int'($urandom_range(0, 6)) - 3);
      default: return oal_pkg::VAL_W'($urandom());
    endcase
  endfunction

  // operation mix per phase: insert, delete_at, delete_value, read, find, max, unused
  function automatic logic [oal_pkg::OP_W-1:0] pick_op(phase_t ph);
    int cut [6];
    int r;
    case (ph)
      PH_FILL:  cut = '{88, 90, 92, 94, 96, 98};
      PH_DRAIN: cut = '{10, 45, 70, 80, 88, 96};
      default:  cut = '{30, 45, 58, 72, 84, 96};
    endcase
    r = $urandom_range(0, 99);
    if (r < cut[0]) return oal_pkg::OP_INSERT_AT;
    if (r < cut[1]) return oal_pkg::OP_DELETE_AT;
    if (r < cut[2]) return oal_pkg::OP_DELETE_VALUE;
    if (r < cut[3]) return oal_pkg::OP_READ_AT;
    if (r < cut[4]) return oal_pkg::OP_FIND_VALUE;
    if (r < cut[5]) return oal_pkg::OP_GET_MAX;
    return r[0] ? OP_UNUSED_A : OP_UNUSED_B;
  endfunction

  // at/insert ops: mostly legal for the current length, else mostly out of range
  function automatic logic [oal_pkg::POS_W-1:0] pick_position(logic [oal_pkg::OP_W-1:0] op,
                                                              int len);
    int hi;
    case (op)
      oal_pkg::OP_INSERT_AT:                     hi = len + 1;
      oal_pkg::OP_DELETE_AT, oal_pkg::OP_READ_AT: hi = len;
      default:                                   return oal_pkg::POS_W'($urandom());
    endcase
    if (hi >= 1 && $urandom_range(0, 99) < 85) begin
      return oal_pkg::POS_W'($urandom_range(1, hi));
    end
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return oal_pkg::POS_W'($urandom_range(hi + 1, 255));
      default: return oal_pkg::POS_W'($urandom());
    endcase
  endfunction

  // one request transfer, after an optional idle gap
  task automatic send_request(logic [oal_pkg::OP_W-1:0] op, logic [oal_pkg::POS_W-1:0] pos,
                              logic signed [oal_pkg::VAL_W-1:0] val);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_value_in  <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender until every outstanding reply has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_due != 0);
  endtask

  // result side backpressure
  initial begin
    int run;
    int gap;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      run = $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      gap = idle_cycles();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("testbench: errors");
    $finish;
  end

  // main stimulus
  initial begin
    phase_t                   ph;
    int                       sent;
    int                       phase_no;
    int                       span;
    logic [oal_pkg::OP_W-1:0] op;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: every lookup and removal fails
    send_request(oal_pkg::OP_GET_MAX, 0, 0);
    send_request(oal_pkg::OP_READ_AT, 1, 0);
    send_request(oal_pkg::OP_DELETE_AT, 1, 0);
    send_request(oal_pkg::OP_DELETE_VALUE, 0, 5);
    send_request(oal_pkg::OP_FIND_VALUE, 0, 5);
    // insert at position zero and past length+1
    send_request(oal_pkg::OP_INSERT_AT, 0, 9);
    send_request(oal_pkg::OP_INSERT_AT, 2, 9);
    // build -128 0 127 127 with front, end and middle inserts
    send_request(oal_pkg::OP_INSERT_AT, 1, 127);
    send_request(oal_pkg::OP_INSERT_AT, 1, -128);
    send_request(oal_pkg::OP_INSERT_AT, 3, 127);
    send_request(oal_pkg::OP_INSERT_AT, 2, 0);
    // repeated maximum reports its first position
    send_request(oal_pkg::OP_GET_MAX, 255, -1);
    send_request(oal_pkg::OP_FIND_VALUE, 0, 127);
    send_request(oal_pkg::OP_FIND_VALUE, 0, 55);
    send_request(oal_pkg::OP_READ_AT, 4, 0);
    send_request(oal_pkg::OP_READ_AT, 5, 0);
    send_request(oal_pkg::OP_READ_AT, 255, 0);
    send_request(oal_pkg::OP_DELETE_AT, 1, 0);
    send_request(oal_pkg::OP_DELETE_VALUE, 0, 127);
    // maximum sitting in the first entry
    send_request(oal_pkg::OP_INSERT_AT, 1, 127);
    send_request(oal_pkg::OP_GET_MAX, 0, 0);
    // undefined operation codes
    send_request(OP_UNUSED_A, 255, -1);
    send_request(OP_UNUSED_B, 128, 127);
    send_request(oal_pkg::OP_DELETE_VALUE, 0, -128);
    send_request(oal_pkg::OP_DELETE_AT, 3, 0);
    settle();

    // random phases: grow the list towards full, mix, grow it again and shrink it
    sent = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase_no % 4)
        0, 2:    ph = PH_FILL;
        1:       ph = PH_MIX;
        default: ph = PH_DRAIN;
      endcase
      calm = (phase_no % 3 == 2);
      span = $urandom_range(80, 150);
      if (span > RANDOM_ITEMS - sent) span = RANDOM_ITEMS - sent;
      repeat (span) begin
        op = pick_op(ph);
        send_request(op, pick_position(op, list_len), pick_value());
        sent++;
      end
      calm = 1'b0;
      settle();
      phase_no++;
    end

    // drain and verdict
    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && replies_due == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
